FILE: sv/table_linear_interpolator_macros.svh
// Assertion macros shared by the interpolator RTL.
// Both macros sample on clock and are disabled during reset.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define TLI_ASSERT_NOW(label, cond_a, cond_c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_c)) \
      else $error(msg);

// Next-cycle implication.
`define TLI_ASSERT_NEXT(label, cond_a, cond_c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_c)) \
      else $error(msg);

`endif

FILE: sv/tli_pkg.sv
// Package for the table interpolator: widths, breakpoint ROM and segment modes.
// No dependencies.
package tli_pkg;

   localparam int TABLE_ENTRIES = 31;
   localparam int WL_W          = 16;
   localparam int VAL_W         = 16;
   localparam int QUO_W         = VAL_W;
   localparam int PROD_W        = VAL_W + WL_W;
   localparam int NUM_W         = PROD_W + 1;
   localparam int SEG_W         = $clog2(TABLE_ENTRIES);

   localparam logic [VAL_W-1:0] DEFAULT_REAL = VAL_W'(4096);

   typedef struct packed {
      logic [WL_W-1:0]  wl;
      logic [VAL_W-1:0] re;
      logic [VAL_W-1:0] im;
   } bp_type;

   typedef enum logic [1:0] {
      MODE_LOW,
      MODE_HIGH,
      MODE_SEG,
      MODE_NONE
   } mode_type;

   // Breakpoints sorted by wavelength (0.1 nm); values in Q4.12.
   function automatic bp_type rom_entry(input logic [SEG_W-1:0] idx);
      bp_type e;
      case (idx)
         5'd0:    e = '{wl: 16'd620,   re: 16'd4198,  im: 16'd590};
         5'd1:    e = '{wl: 16'd827,   re: 16'd3424,  im: 16'd1155};
         5'd2:    e = '{wl: 16'd1240,  re: 16'd3740,  im: 16'd3990};
         5'd3:    e = '{wl: 16'd1378,  re: 16'd3690,  im: 16'd4653};
         5'd4:    e = '{wl: 16'd1550,  re: 16'd3682,  im: 16'd5878};
         5'd5:    e = '{wl: 16'd1771,  re: 16'd4354,  im: 16'd7528};
         5'd6:    e = '{wl: 16'd2066,  re: 16'd5177,  im: 16'd10125};
         5'd7:    e = '{wl: 16'd2254,  re: 16'd5665,  im: 16'd12026};
         5'd8:    e = '{wl: 16'd2480,  re: 16'd9310,  im: 16'd16728};
         5'd9:    e = '{wl: 16'd2755,  re: 16'd16028, im: 16'd11956};
         5'd10:   e = '{wl: 16'd3100,  re: 16'd14750, im: 16'd7864};
         5'd11:   e = '{wl: 16'd3542,  re: 16'd14463, im: 16'd8245};
         5'd12:   e = '{wl: 16'd4133,  re: 16'd18469, im: 16'd7979};
         5'd13:   e = '{wl: 16'd4275,  re: 16'd20693, im: 16'd7049};
         5'd14:   e = '{wl: 16'd4428,  re: 16'd20312, im: 16'd4059};
         5'd15:   e = '{wl: 16'd4592,  re: 16'd19227, im: 16'd2851};
         5'd16:   e = '{wl: 16'd4769,  re: 16'd18399, im: 16'd2208};
         5'd17:   e = '{wl: 16'd4959,  re: 16'd17748, im: 16'd1806};
         5'd18:   e = '{wl: 16'd5166,  re: 16'd17224, im: 16'd1520};
         5'd19:   e = '{wl: 16'd5391,  re: 16'd16794, im: 16'd1311};
         5'd20:   e = '{wl: 16'd5636,  re: 16'd16437, im: 16'd1130};
         5'd21:   e = '{wl: 16'd5904,  re: 16'd15991, im: 16'd983};
         5'd22:   e = '{wl: 16'd6199,  re: 16'd15884, im: 16'd864};
         5'd23:   e = '{wl: 16'd6526,  re: 16'd15671, im: 16'd733};
         5'd24:   e = '{wl: 16'd6888,  re: 16'd15503, im: 16'd618};
         5'd25:   e = '{wl: 16'd7293,  re: 16'd15327, im: 16'd459};
         5'd26:   e = '{wl: 16'd7749,  re: 16'd15155, im: 16'd373};
         5'd27:   e = '{wl: 16'd8266,  re: 16'd15016, im: 16'd328};
         5'd28:   e = '{wl: 16'd8856,  re: 16'd14803, im: 16'd8};
         5'd29:   e = '{wl: 16'd10000, re: 16'd14373, im: 16'd0};
         5'd30:   e = '{wl: 16'd20000, re: 16'd14373, im: 16'd0};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

FILE: sv/table_linear_interpolator.sv
// Piecewise-linear complex index lookup over a fixed breakpoint ROM.
// Uses tli_pkg and the assertion macros in table_linear_interpolator_macros.svh.
//
// Usage:
//  - req channel: req_wavelength (0.1 nm units) with req_valid / req_stall.
//  - rsp channel: rsp_index_real / rsp_index_imag (unsigned Q4.12) with
//    rsp_valid / rsp_stall. One response per request, in request order.
//  - Path from an accepted request to rsp_valid: segment search, ROM
//    fetch, multiply-accumulate, then a 16-stage restoring divider that
//    resolves one quotient bit per stage.
//  - Throughput: one request per cycle while req_stall is low; the
//    divider pipeline sets depth, not rate.
//  - Out-of-range wavelengths return the nearest end breakpoint. A
//    wavelength equal to an inner breakpoint returns its values exactly.
//  - Reset clears all valid bits; no response is pending afterward.
//  - When rsp_valid is held by rsp_stall the whole pipeline freezes and
//    req_stall rises in the same cycle; bubbles keep flowing otherwise.
//  - Latency is fixed apart from stall cycles.
`include "table_linear_interpolator_macros.svh"

module table_linear_interpolator
   import tli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WL_W-1:0]  req_wavelength,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [VAL_W-1:0] rsp_index_real,
   output logic [VAL_W-1:0] rsp_index_imag
);

   logic adv;

   // ---------------- stage 1: segment search ----------------
   logic [TABLE_ENTRIES-2:0] hit;
   logic [SEG_W-1:0]         s1_seg_in;
   mode_type                 s1_mode_in;
   bp_type                   first_e, last_e, lo_e, hi_e;

   logic             s1_valid_ff;
   mode_type         s1_mode_ff;
   logic [SEG_W-1:0] s1_seg_ff;
   logic [WL_W-1:0]  s1_wl_ff;

   always_comb begin
      first_e = rom_entry(SEG_W'(0));
      last_e  = rom_entry(SEG_W'(TABLE_ENTRIES - 1));
      lo_e    = '0;
      hi_e    = '0;
      for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
         lo_e   = rom_entry(SEG_W'(i));
         hi_e   = rom_entry(SEG_W'(i + 1));
         hit[i] = (req_wavelength >= lo_e.wl) && (req_wavelength <= hi_e.wl);
      end
      // lowest segment wins
      s1_seg_in = '0;
      for (int i = TABLE_ENTRIES - 2; i >= 0; i--) begin
         if (hit[i]) begin
            s1_seg_in = SEG_W'(i);
         end
      end
      if (req_wavelength < first_e.wl) begin
         s1_mode_in = MODE_LOW;
      end else if (req_wavelength > last_e.wl) begin
         s1_mode_in = MODE_HIGH;
      end else if (|hit) begin
         s1_mode_in = MODE_SEG;
      end else begin
         s1_mode_in = MODE_NONE;
      end
   end

   // ---------------- stage 2: ROM fetch, offsets ----------------
   // Non-interpolated cases are folded in as value * 1 / 1.
   bp_type          e0, e1;
   logic [WL_W-1:0] seg_width;

   logic [VAL_W-1:0] s2_v0re_in, s2_v1re_in, s2_v0im_in, s2_v1im_in;
   logic [WL_W-1:0]  s2_d1_in, s2_d2_in, s2_div_in;

   logic             s2_valid_ff;
   logic [VAL_W-1:0] s2_v0re_ff, s2_v1re_ff, s2_v0im_ff, s2_v1im_ff;
   logic [WL_W-1:0]  s2_d1_ff, s2_d2_ff, s2_div_ff;

   always_comb begin
      e0         = rom_entry(s1_seg_ff);
      e1         = rom_entry(s1_seg_ff + SEG_W'(1));
      seg_width  = e1.wl - e0.wl;
      s2_v0re_in = '0;
      s2_v0im_in = '0;
      s2_v1re_in = '0;
      s2_v1im_in = '0;
      s2_d1_in   = '0;
      s2_d2_in   = WL_W'(1);
      s2_div_in  = WL_W'(1);
      case (s1_mode_ff)
         MODE_LOW: begin
            s2_v0re_in = first_e.re;
            s2_v0im_in = first_e.im;
         end
         MODE_HIGH: begin
            s2_v0re_in = last_e.re;
            s2_v0im_in = last_e.im;
         end
         MODE_SEG: begin
            s2_v0re_in = e0.re;
            s2_v0im_in = e0.im;
            if (seg_width != '0) begin
               s2_v1re_in = e1.re;
               s2_v1im_in = e1.im;
               s2_d1_in   = s1_wl_ff - e0.wl;
               s2_d2_in   = e1.wl - s1_wl_ff;
               s2_div_in  = seg_width;
            end
         end
         default: begin
            s2_v0re_in = DEFAULT_REAL;
         end
      endcase
   end

   // ---------------- stage 3: weighted sum plus half divisor ----------------
   logic [PROD_W-1:0] p_re0, p_re1, p_im0, p_im1;
   logic [NUM_W-1:0]  s3_num_re_in, s3_num_im_in;

   logic             s3_valid_ff;
   logic [NUM_W-1:0] s3_num_re_ff, s3_num_im_ff;
   logic [WL_W-1:0]  s3_div_ff;

   always_comb begin
      p_re0 = PROD_W'(s2_v0re_ff) * PROD_W'(s2_d2_ff);
      p_re1 = PROD_W'(s2_v1re_ff) * PROD_W'(s2_d1_ff);
      p_im0 = PROD_W'(s2_v0im_ff) * PROD_W'(s2_d2_ff);
      p_im1 = PROD_W'(s2_v1im_ff) * PROD_W'(s2_d1_ff);
      s3_num_re_in = NUM_W'(p_re0) + NUM_W'(p_re1) + NUM_W'(s2_div_ff >> 1);
      s3_num_im_in = NUM_W'(p_im0) + NUM_W'(p_im1) + NUM_W'(s2_div_ff >> 1);
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic             dv_valid_ff  [QUO_W];
   logic [NUM_W-1:0] dv_rem_re_ff [QUO_W];
   logic [NUM_W-1:0] dv_rem_im_ff [QUO_W];
   logic [QUO_W-1:0] dv_quo_re_ff [QUO_W];
   logic [QUO_W-1:0] dv_quo_im_ff [QUO_W];
   logic [WL_W-1:0]  dv_div_ff    [QUO_W];

   logic             dv_valid_in  [QUO_W];
   logic [NUM_W-1:0] dv_rem_re_in [QUO_W];
   logic [NUM_W-1:0] dv_rem_im_in [QUO_W];
   logic [QUO_W-1:0] dv_quo_re_in [QUO_W];
   logic [QUO_W-1:0] dv_quo_im_in [QUO_W];
   logic [WL_W-1:0]  dv_div_in    [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int BIT = QUO_W - 1 - k;
      logic             vld_src;
      logic [NUM_W-1:0] rre_src, rim_src, trial;
      logic [QUO_W-1:0] qre_src, qim_src;
      logic [WL_W-1:0]  div_src;
      logic             ge_re, ge_im;

      if (k == 0) begin : g_first
         assign vld_src = s3_valid_ff;
         assign rre_src = s3_num_re_ff;
         assign rim_src = s3_num_im_ff;
         assign qre_src = '0;
         assign qim_src = '0;
         assign div_src = s3_div_ff;
      end else begin : g_next
         assign vld_src = dv_valid_ff[k-1];
         assign rre_src = dv_rem_re_ff[k-1];
         assign rim_src = dv_rem_im_ff[k-1];
         assign qre_src = dv_quo_re_ff[k-1];
         assign qim_src = dv_quo_im_ff[k-1];
         assign div_src = dv_div_ff[k-1];
      end

      assign trial           = NUM_W'(div_src) << BIT;
      assign ge_re           = rre_src >= trial;
      assign ge_im           = rim_src >= trial;
      assign dv_valid_in[k]  = vld_src;
      assign dv_div_in[k]    = div_src;
      assign dv_rem_re_in[k] = ge_re ? rre_src - trial : rre_src;
      assign dv_rem_im_in[k] = ge_im ? rim_src - trial : rim_src;
      assign dv_quo_re_in[k] = qre_src | (QUO_W'(ge_re) << BIT);
      assign dv_quo_im_in[k] = qim_src | (QUO_W'(ge_im) << BIT);
   end

   // ---------------- flow control ----------------
   assign adv       = !dv_valid_ff[QUO_W-1] || !rsp_stall;
   assign req_stall = !adv;

   assign rsp_valid      = dv_valid_ff[QUO_W-1];
   assign rsp_index_real = dv_quo_re_ff[QUO_W-1];
   assign rsp_index_imag = dv_quo_im_ff[QUO_W-1];

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         for (int k = 0; k < QUO_W; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         for (int k = 0; k < QUO_W; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff   <= s1_mode_in;
         s1_seg_ff    <= s1_seg_in;
         s1_wl_ff     <= req_wavelength;
         s2_v0re_ff   <= s2_v0re_in;
         s2_v1re_ff   <= s2_v1re_in;
         s2_v0im_ff   <= s2_v0im_in;
         s2_v1im_ff   <= s2_v1im_in;
         s2_d1_ff     <= s2_d1_in;
         s2_d2_ff     <= s2_d2_in;
         s2_div_ff    <= s2_div_in;
         s3_num_re_ff <= s3_num_re_in;
         s3_num_im_ff <= s3_num_im_in;
         s3_div_ff    <= s2_div_ff;
         for (int k = 0; k < QUO_W; k++) begin
            dv_rem_re_ff[k] <= dv_rem_re_in[k];
            dv_rem_im_ff[k] <= dv_rem_im_in[k];
            dv_quo_re_ff[k] <= dv_quo_re_in[k];
            dv_quo_im_ff[k] <= dv_quo_im_in[k];
            dv_div_ff[k]    <= dv_div_in[k];
         end
      end
   end

   // ---------------- assertions ----------------
   logic quo_fits, rem_reduced;

   assign quo_fits    = (s3_num_re_ff >> QUO_W) < NUM_W'(s3_div_ff) &&
                        (s3_num_im_ff >> QUO_W) < NUM_W'(s3_div_ff);
   assign rem_reduced = dv_rem_re_ff[QUO_W-1] < NUM_W'(dv_div_ff[QUO_W-1]) &&
                        dv_rem_im_ff[QUO_W-1] < NUM_W'(dv_div_ff[QUO_W-1]);

   `TLI_ASSERT_NOW(a_div_nonzero, s2_valid_ff, s2_div_ff != '0, "segment width is zero")
   `TLI_ASSERT_NOW(a_quo_fits, s3_valid_ff, quo_fits, "quotient overflows")
   `TLI_ASSERT_NOW(a_rem_final, rsp_valid, rem_reduced, "divider remainder not reduced")
   `TLI_ASSERT_NEXT(a_freeze, rsp_valid && rsp_stall, $stable(s3_num_re_ff) && $stable(s3_valid_ff), "pipeline moved during stall")

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for table_linear_interpolator: wavelength lookups in,
// complex index out, checked against a local breakpoint-table interpolator.
// Depends on tli_pkg for port widths and the default real index.
module tb_top
   import tli_pkg::*;
();

   typedef struct {
      logic [WL_W-1:0] wl;
      bit              drain;   // hold off until every result is back
   } lookup_req_type;

   typedef struct {
      logic [WL_W-1:0]  wl;
      logic [VAL_W-1:0] re;
      logic [VAL_W-1:0] im;
   } index_pair_type;

   localparam int IDLE_LIMIT = 2000;
   localparam int QUIET_TAIL = 150;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [WL_W-1:0]  req_wavelength = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [VAL_W-1:0] rsp_index_real;
   logic [VAL_W-1:0] rsp_index_imag;

   // Breakpoint wavelengths (0.1 nm) and Q4.12 index values.
   int unsigned bp_wl [TABLE_ENTRIES] = '{
      620, 827, 1240, 1378, 1550, 1771, 2066, 2254, 2480, 2755, 3100,
      3542, 4133, 4275, 4428, 4592, 4769, 4959, 5166, 5391, 5636, 5904,
      6199, 6526, 6888, 7293, 7749, 8266, 8856, 10000, 20000};
   int unsigned bp_re [TABLE_ENTRIES] = '{
      4198, 3424, 3740, 3690, 3682, 4354, 5177, 5665, 9310, 16028, 14750,
      14463, 18469, 20693, 20312, 19227, 18399, 17748, 17224, 16794, 16437,
      15991, 15884, 15671, 15503, 15327, 15155, 15016, 14803, 14373, 14373};
   int unsigned bp_im [TABLE_ENTRIES] = '{
      590, 1155, 3990, 4653, 5878, 7528, 10125, 12026, 16728, 11956, 7864,
      8245, 7979, 7049, 4059, 2851, 2208, 1806, 1520, 1311, 1130, 983, 864,
      733, 618, 459, 373, 328, 8, 0, 0};

   lookup_req_type pending [$];
   index_pair_type index_expected [$];
   int          results_owed = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          cycle_count = 0;
   bit          quiet = 1'b0;

   table_linear_interpolator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_wavelength (req_wavelength),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_index_real (rsp_index_real),
      .rsp_index_imag (rsp_index_imag)
   );

   always #1 clock = ~clock;

   // Clamp to the end entries, otherwise interpolate in the first segment
   // that holds the wavelength, rounding halves up.
   function automatic index_pair_type interpolate_index(input logic [WL_W-1:0] wl);
      index_pair_type   r;
      longint unsigned  w, d1, d2;
      bit               found;
      r.wl  = wl;
      r.re  = DEFAULT_REAL;
      r.im  = '0;
      found = 1'b0;
      if (wl < bp_wl[0]) begin
         r.re = VAL_W'(bp_re[0]);
         r.im = VAL_W'(bp_im[0]);
      end else if (wl > bp_wl[TABLE_ENTRIES-1]) begin
         r.re = VAL_W'(bp_re[TABLE_ENTRIES-1]);
         r.im = VAL_W'(bp_im[TABLE_ENTRIES-1]);
      end else begin
         for (int i = 0; i + 1 < TABLE_ENTRIES; i++) begin
            if (!found && wl >= bp_wl[i] && wl <= bp_wl[i+1]) begin
               found = 1'b1;
               w = bp_wl[i+1] - bp_wl[i];
               if (w == 0) begin
                  r.re = VAL_W'(bp_re[i]);
                  r.im = VAL_W'(bp_im[i]);
               end else begin
                  d1   = wl - bp_wl[i];
                  d2   = bp_wl[i+1] - wl;
                  r.re = VAL_W'((bp_re[i] * d2 + bp_re[i+1] * d1 + w / 2) / w);
                  r.im = VAL_W'((bp_im[i] * d2 + bp_im[i+1] * d1 + w / 2) / w);
               end
            end
         end
      end
      return r;
   endfunction

   // Mostly in-table wavelengths, with breakpoint neighbors and full-range noise.
   function automatic logic [WL_W-1:0] pick_wavelength();
      int unsigned sel, k;
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, TABLE_ENTRIES - 1);
      if (sel < 55)
         return WL_W'($urandom_range(620, 10000));
      else if (sel < 70)
         return WL_W'(bp_wl[k] + $urandom_range(0, 2) - 1);
      else if (sel < 80)
         return WL_W'($urandom_range(10000, 20000));
      else
         return WL_W'($urandom_range(0, 65535));
   endfunction

   task automatic add_lookup(input logic [WL_W-1:0] wl, input bit drain);
      lookup_req_type q;
      q.wl    = wl;
      q.drain = drain;
      pending = {pending, q};
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         quiet <= (pending.size() < QUIET_TAIL);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain && (req_valid || results_owed != 0))) begin
               req_valid      <= 1'b1;
               req_wavelength <= pending[0].wl;
               void'(pending.pop_front());
               if (!quiet && $urandom_range(0, 5) == 0)
                  send_gap <= $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response backpressure: bursts, with calm stretches while bit 8 of cycle_count is set.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && !cycle_count[8] && !rsp_stall && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check responses in order, predict on accepted requests.
   always @(posedge clock) begin
      index_pair_type exp_idx;
      bit             moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (index_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: real=%0d imag=%0d",
                           rsp_index_real, rsp_index_imag);
            end else begin
               exp_idx = index_expected.pop_front();
               if (rsp_index_real !== exp_idx.re || rsp_index_imag !== exp_idx.im) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("wl=%0d: real exp %0d got %0d, imag exp %0d got %0d",
                              exp_idx.wl, exp_idx.re, rsp_index_real,
                              exp_idx.im, rsp_index_imag);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            index_expected = {index_expected, interpolate_index(req_wavelength)};
         end
         results_owed <= index_expected.size();
         idle_cycles  <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      // ends of the input range and every bit both ways
      add_lookup(16'd0, 1'b0);
      add_lookup(16'd65535, 1'b0);
      add_lookup(16'hAAAA, 1'b0);
      add_lookup(16'h5555, 1'b0);
      // below, at and just inside the first breakpoint
      add_lookup(16'd619, 1'b0);
      add_lookup(16'd620, 1'b0);
      add_lookup(16'd621, 1'b0);
      // exact inner breakpoints and their neighbors
      add_lookup(16'd826, 1'b0);
      add_lookup(16'd827, 1'b0);
      add_lookup(16'd828, 1'b0);
      add_lookup(16'd2480, 1'b0);
      add_lookup(16'd2755, 1'b0);
      add_lookup(16'd4133, 1'b0);
      add_lookup(16'd8856, 1'b0);
      add_lookup(16'd9999, 1'b0);
      add_lookup(16'd10000, 1'b0);
      add_lookup(16'd10001, 1'b0);
      // flat last segment, the upper clamp, then two points inside inner segments
      add_lookup(16'd15000, 1'b0);
      add_lookup(16'd19999, 1'b0);
      add_lookup(16'd20000, 1'b0);
      add_lookup(16'd20001, 1'b0);
      add_lookup(16'd2617, 1'b0);
      add_lookup(16'd5000, 1'b0);
      for (int n = 0; n < 1330; n++)
         add_lookup(pick_wavelength(), n == 0 || n == 650);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid || results_owed != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && index_expected.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
